// ===== rtl/ntc_pkg.sv =====
// shared types and constants for the ntc adc to temperature pipeline
package ntc_pkg;

  localparam int ADC_WIDTH  = 16;
  localparam int R1_W       = 20;
  localparam int COEF_W     = 56;
  localparam int CFG_W      = 56;
  localparam int LOG_STEPS  = 24;
  localparam int MANT_W     = 31;
  localparam int FRAC_W     = 24;
  localparam int X_W        = R1_W + ADC_WIDTH;
  localparam int XK_W       = 6;
  localparam int SK_W       = 4;
  localparam int QUO_BITS   = 16;
  localparam int REM_W      = 62;
  localparam int DIV_W      = REM_W + QUO_BITS;
  localparam int ACC_W      = 100;

  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  localparam int          KELVIN_CENTI = 27315;

  typedef enum logic [2:0] {
    REG_FULL_SCALE = 3'd0,
    REG_R1         = 3'd1,
    REG_COEF_A     = 3'd2,
    REG_COEF_B     = 3'd3,
    REG_COEF_D     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic              ok;
    logic [XK_W-1:0]   k_num;
    logic [SK_W-1:0]   k_den;
    logic [MANT_W-1:0] m_num;
    logic [MANT_W-1:0] m_den;
    logic [FRAC_W-1:0] f_num;
    logic [FRAC_W-1:0] f_den;
  } log_word_t;

  typedef struct packed {
    logic ok;
    logic pneg;
    logic huge;
    logic zero;
    logic big;
  } div_flags_t;

  typedef struct packed {
    div_flags_t          flags;
    logic [REM_W-1:0]    rem;
    logic [DIV_W-1:0]    dvs;
    logic [QUO_BITS-1:0] quo;
  } div_word_t;

endpackage

// ===== rtl/ntc_log_cell.sv =====
// one fraction bit of log2 for numerator and denominator by squaring
module ntc_log_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  ntc_pkg::log_word_t in_word,
  output logic               out_vld,
  output ntc_pkg::log_word_t out_word
);
  import ntc_pkg::*;

  logic                vld_r;
  log_word_t           word_r;
  log_word_t           word_nxt;
  logic [2*MANT_W-1:0] sq_num;
  logic [2*MANT_W-1:0] sq_den;
  logic [MANT_W:0]     t_num;
  logic [MANT_W:0]     t_den;

  always_comb begin
    sq_num = in_word.m_num * in_word.m_num;
    sq_den = in_word.m_den * in_word.m_den;
    t_num  = sq_num[2*MANT_W-1:MANT_W-1];
    t_den  = sq_den[2*MANT_W-1:MANT_W-1];
    word_nxt       = in_word;
    // square back in [1,2) after a halving when it reached two
    word_nxt.m_num = t_num[MANT_W] ? t_num[MANT_W:1] : t_num[MANT_W-1:0];
    word_nxt.m_den = t_den[MANT_W] ? t_den[MANT_W:1] : t_den[MANT_W-1:0];
    word_nxt.f_num = {in_word.f_num[FRAC_W-2:0], t_num[MANT_W]};
    word_nxt.f_den = {in_word.f_den[FRAC_W-2:0], t_den[MANT_W]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_word = word_r;

endmodule

// ===== rtl/ntc_div_cell.sv =====
// one quotient bit of the restoring division
module ntc_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  ntc_pkg::div_word_t in_word,
  output logic               out_vld,
  output ntc_pkg::div_word_t out_word
);
  import ntc_pkg::*;

  logic             vld_r;
  div_word_t        word_r;
  div_word_t        word_nxt;
  logic [DIV_W-1:0] dvs_sh;
  logic             ge;

  always_comb begin
    dvs_sh   = in_word.dvs >> 1;
    ge       = {{QUO_BITS{1'b0}}, in_word.rem} >= dvs_sh;
    word_nxt = in_word;
    word_nxt.dvs = dvs_sh;
    word_nxt.rem = ge ? (in_word.rem - dvs_sh[REM_W-1:0]) : in_word.rem;
    word_nxt.quo = {in_word.quo[QUO_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_word = word_r;

endmodule

// ===== rtl/ntc_adc_to_temperature_unit.sv =====
// ntc thermistor adc code to temperature in hundredths of a degree, pipelined
// one word per cycle sustained while the output is not stalled
// the depth comes mainly from the 24 log2 squaring cells and the 16 division cells
// a stall on the output freezes the whole pipe; input ready follows output space
// reset (synchronous, active low) empties the pipe and loads default registers
module ntc_adc_to_temperature_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // [15:0] adc_sample
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // [15:0] temp_centi_celsius
  output logic                        out_tuser,  // [0] temp_valid
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_addr,
  input  logic [ntc_pkg::CFG_W-1:0]   cfg_wdata
);
  import ntc_pkg::*;

  // configuration
  logic [15:0]       fs_r;
  logic [R1_W-1:0]   r1_r;
  logic [COEF_W-1:0] ca_r;
  logic [COEF_W-1:0] cb_r;
  logic [COEF_W-1:0] cd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= 16'd4095;
      r1_r <= 20'd1000;
      ca_r <= 56'sd11931378499532;
      cb_r <= -56'sd2663411417683;
      cd_r <= 56'sd29953198331;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_FULL_SCALE: fs_r <= cfg_wdata[15:0];
        REG_R1:         r1_r <= cfg_wdata[R1_W-1:0];
        REG_COEF_A:     ca_r <= cfg_wdata[COEF_W-1:0];
        REG_COEF_B:     cb_r <= cfg_wdata[COEF_W-1:0];
        REG_COEF_D:     cd_r <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // coefficient magnitudes, split for the multipliers
  logic [COEF_W-1:0] cb_mag;
  logic [COEF_W-1:0] cd_mag;
  assign cb_mag = cb_r[COEF_W-1] ? (~cb_r + 1'b1) : cb_r;
  assign cd_mag = cd_r[COEF_W-1] ? (~cd_r + 1'b1) : cd_r;

  // input stage
  logic [ADC_WIDTH-1:0] s_in;
  logic [ADC_WIDTH-1:0] fs_m;
  logic                 ok_in;
  logic                 v0_r;
  logic                 ok0_r;
  logic [X_W-1:0]       x0_r;
  logic [ADC_WIDTH-1:0] s0_r;

  assign s_in  = in_tdata[ADC_WIDTH-1:0];
  assign fs_m  = fs_r[ADC_WIDTH-1:0];
  assign ok_in = (s_in < fs_m) && (s_in != '0) && (r1_r != '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      ok0_r <= ok_in;
      x0_r  <= r1_r * (fs_m - s_in);
      s0_r  <= s_in;
    end
  end

  // normalize both arguments to a mantissa in [1,2)
  logic [XK_W-1:0]   kx;
  logic [SK_W-1:0]   ks;
  logic [X_W-1:0]    xs;
  logic [MANT_W-1:0] ss;
  log_word_t         lw0;

  always_comb begin
    kx = '0;
    ks = '0;
    for (int i = 0; i < X_W; i++) begin
      if (x0_r[i]) kx = XK_W'(i);
    end
    for (int i = 0; i < ADC_WIDTH; i++) begin
      if (s0_r[i]) ks = SK_W'(i);
    end
    if (kx <= XK_W'(MANT_W - 1)) begin
      xs = x0_r << (XK_W'(MANT_W - 1) - kx);
    end else begin
      xs = x0_r >> (kx - XK_W'(MANT_W - 1));
    end
    ss = {{(MANT_W-ADC_WIDTH){1'b0}}, s0_r} << (5'(MANT_W - 1) - {1'b0, ks});
    lw0.ok    = ok0_r;
    lw0.k_num = kx;
    lw0.k_den = ks;
    lw0.m_num = xs[MANT_W-1:0];
    lw0.m_den = ss;
    lw0.f_num = '0;
    lw0.f_den = '0;
  end

  // log2 squaring chain
  log_word_t lw [0:LOG_STEPS];
  logic      lv [0:LOG_STEPS];
  assign lw[0] = lw0;
  assign lv[0] = v0_r;

  for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
    ntc_log_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_vld   (lv[g]),
      .in_word  (lw[g]),
      .out_vld  (lv[g+1]),
      .out_word (lw[g+1])
    );
  end

  // polynomial stages
  localparam int LOGV_W = XK_W + FRAC_W;
  localparam int LM_W   = 30;
  localparam int L2_W   = 36;
  localparam int L3_W   = 42;
  localparam int HALF_W = COEF_W / 2;
  localparam int BP_W   = COEF_W + LM_W;
  localparam int DP_W   = COEF_W + L3_W;

  logic [LOGV_W-1:0] lnum;
  logic [LOGV_W-1:0] lden;
  assign lnum = {lw[LOG_STEPS].k_num, lw[LOG_STEPS].f_num};
  assign lden = {{(XK_W-SK_W){1'b0}}, lw[LOG_STEPS].k_den, lw[LOG_STEPS].f_den};

  logic [8:1] v_r;
  logic [8:1] ok_r;
  logic [5:1] lneg_r;

  logic [LOGV_W-1:0]      dmag1_r;
  logic [LM_W-1:0]        lmag2_r;
  logic [LM_W-1:0]        lmag3_r;
  logic [L2_W-1:0]        l2_3_r;
  logic [L3_W-1:0]        l3_4_r;
  logic [HALF_W+LM_W-1:0] bpl4_r;
  logic [HALF_W+LM_W-1:0] bph4_r;
  logic [BP_W-1:0]        bp5_r;
  logic [HALF_W+L3_W-1:0] dpl5_r;
  logic [HALF_W+L3_W-1:0] dph5_r;
  logic signed [ACC_W-1:0] ta6_r;
  logic signed [ACC_W-1:0] tb6_r;
  logic signed [ACC_W-1:0] td6_r;
  logic signed [ACC_W-1:0] acc7_r;
  logic                    pneg8_r;
  logic [ACC_W-1:0]        mag8_r;

  logic [LOGV_W+31:0]     lm_prod;
  logic [2*LM_W-1:0]      l2_prod;
  logic [L2_W+LM_W-1:0]   l3_prod;
  logic [DP_W-1:0]        dp_sum;
  logic signed [ACC_W-1:0] ta_c;

  always_comb begin
    lm_prod = dmag1_r * LN2_Q32 + (LOGV_W+32)'(64'h8000_0000);
    l2_prod = lmag2_r * lmag2_r + (2*LM_W)'(24'h80_0000);
    l3_prod = l2_3_r * lmag3_r + (L2_W+LM_W)'(24'h80_0000);
    dp_sum  = {dph5_r, {HALF_W{1'b0}}} + DP_W'(dpl5_r);
    ta_c    = ACC_W'($signed(ca_r)) <<< 24;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok_r[1]   <= lw[LOG_STEPS].ok;
      lneg_r[1] <= lnum < lden;
      dmag1_r   <= (lnum < lden) ? (lden - lnum) : (lnum - lden);

      ok_r[2]   <= ok_r[1];
      lneg_r[2] <= lneg_r[1];
      lmag2_r   <= lm_prod[LM_W+31:32];

      ok_r[3]   <= ok_r[2];
      lneg_r[3] <= lneg_r[2];
      lmag3_r   <= lmag2_r;
      l2_3_r    <= l2_prod[L2_W+23:24];

      ok_r[4]   <= ok_r[3];
      lneg_r[4] <= lneg_r[3];
      l3_4_r    <= l3_prod[L3_W+23:24];
      bpl4_r    <= cb_mag[HALF_W-1:0] * lmag3_r;
      bph4_r    <= cb_mag[COEF_W-1:HALF_W] * lmag3_r;

      ok_r[5]   <= ok_r[4];
      lneg_r[5] <= lneg_r[4];
      bp5_r     <= {bph4_r, {HALF_W{1'b0}}} + BP_W'(bpl4_r);
      dpl5_r    <= cd_mag[HALF_W-1:0] * l3_4_r;
      dph5_r    <= cd_mag[COEF_W-1:HALF_W] * l3_4_r;

      ok_r[6]   <= ok_r[5];
      ta6_r     <= ta_c;
      tb6_r     <= (cb_r[COEF_W-1] ^ lneg_r[5]) ? -$signed(ACC_W'(bp5_r))
                                                : $signed(ACC_W'(bp5_r));
      td6_r     <= (cd_r[COEF_W-1] ^ lneg_r[5]) ? -$signed(ACC_W'(dp_sum))
                                                : $signed(ACC_W'(dp_sum));

      ok_r[7]   <= ok_r[6];
      acc7_r    <= ta6_r + tb6_r + td6_r;

      ok_r[8]   <= ok_r[7];
      pneg8_r   <= acc7_r[ACC_W-1];
      mag8_r    <= acc7_r[ACC_W-1] ? ACC_W'(-acc7_r) : ACC_W'(acc7_r);
    end
  end

  // division setup: q = (100 * 2^50 + m50 / 2) / m50
  localparam logic [REM_W-1:0] NUM_BASE = REM_W'(100) << 50;

  logic [REM_W-1:0] m50;
  logic [REM_W-1:0] num;
  logic [DIV_W-1:0] dvs0;
  div_word_t        dw0_nxt;

  always_comb begin
    m50  = mag8_r[REM_W+23:24];
    num  = NUM_BASE + (m50 >> 1);
    dvs0 = {m50, {QUO_BITS{1'b0}}};
    dw0_nxt.flags.ok   = ok_r[8];
    dw0_nxt.flags.pneg = pneg8_r;
    dw0_nxt.flags.huge = |mag8_r[ACC_W-1:REM_W+24];
    dw0_nxt.flags.zero = (m50 == '0);
    // quotient would not fit: result saturates either way
    dw0_nxt.flags.big  = {{QUO_BITS{1'b0}}, num} >= dvs0;
    dw0_nxt.rem  = num;
    dw0_nxt.dvs  = dvs0;
    dw0_nxt.quo  = '0;
  end

  div_word_t dw [0:QUO_BITS];
  logic      dv [0:QUO_BITS];
  logic      v9_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dw[0] <= dw0_nxt;
    end
  end

  assign dv[0] = v9_r;

  for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
    ntc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_vld   (dv[g]),
      .in_word  (dw[g]),
      .out_vld  (dv[g+1]),
      .out_word (dw[g+1])
    );
  end

  // valid tracking outside the cells
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v_r  <= '0;
      v9_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_tvalid;
      v_r  <= {v_r[7:1], lv[LOG_STEPS]};
      v9_r <= v_r[8];
    end
  end

  // final offset and clamp
  div_word_t          dwl;
  logic signed [17:0] tq;
  logic signed [17:0] tc;
  logic [15:0]        temp_nxt;

  always_comb begin
    dwl = dw[QUO_BITS];
    tq  = dwl.flags.pneg ? -$signed({2'b00, dwl.quo}) : $signed({2'b00, dwl.quo});
    tc  = tq - 18'sd27315;
    if (!dwl.flags.ok) begin
      temp_nxt = '0;
    end else if (dwl.flags.huge) begin
      temp_nxt = 16'(-KELVIN_CENTI);
    end else if (dwl.flags.zero || dwl.flags.big) begin
      temp_nxt = dwl.flags.pneg ? 16'h8000 : 16'h7fff;
    end else if (tc > 18'sd32767) begin
      temp_nxt = 16'h7fff;
    end else if (tc < -18'sd32768) begin
      temp_nxt = 16'h8000;
    end else begin
      temp_nxt = tc[15:0];
    end
  end

  logic        out_tvalid_r;
  logic [15:0] out_tdata_r;
  logic        out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= dv[QUO_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= temp_nxt;
      out_tuser_r <= dwl.flags.ok;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== dv/tb_ntc_adc_to_temperature_unit.sv =====
// testbench for the ntc adc to temperature unit: predicted temperatures vs stream output
`timescale 1ns / 1ps

class temp_scoreboard;
  logic [15:0]        full_scale;
  logic [19:0]        r1_ohms;
  logic signed [55:0] ca, cb, cd;
  logic [16:0]        temps_due[$];
  int                 mismatches;
  int                 checked;

  function new();
    full_scale = 16'd4095;
    r1_ohms    = 20'd1000;
    ca         = 56'sd11931378499532;
    cb         = -56'sd2663411417683;
    cd         = 56'sd29953198331;
    mismatches = 0;
    checked    = 0;
  endfunction

  // log2 in q24, mantissa kept in q30 and squared bit by bit
  function automatic logic [63:0] log2_fix(logic [63:0] x);
    int k;
    logic [63:0] m, fr;
    k = 0;
    while (k < 63 && (x >> (k + 1)) != 0) k++;
    if (k <= 30) m = x << (30 - k);
    else m = x >> (k - 30);
    fr = 0;
    for (int i = 0; i < 24; i++) begin
      m  = (m * m) >> 30;
      fr = fr << 1;
      if (m >= 64'h8000_0000) begin
        fr[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(k) << 24) | fr;
  endfunction

  function automatic logic [127:0] signed_term(logic signed [55:0] c, logic [63:0] v,
                                               int sh, logic flip);
    logic [127:0] t;
    logic [63:0]  mag;
    mag = c[55] ? 64'(-longint'(c)) : 64'(c);
    t = (128'(mag) * 128'(v)) << sh;
    return (c[55] ^ flip) ? -t : t;
  endfunction

  // returns {valid, temp}
  function automatic logic [16:0] convert(logic [15:0] s);
    logic [63:0]  nl, dl, dmag, lmag, l2, l3, m50, q;
    logic [127:0] acc;
    logic         lneg, pneg;
    longint       t;
    if (s >= full_scale || s == 0 || r1_ohms == 0) return 17'd0;
    nl   = log2_fix(64'(r1_ohms) * 64'(full_scale - s));
    dl   = log2_fix(64'(s));
    lneg = nl < dl;
    dmag = lneg ? dl - nl : nl - dl;
    lmag = (dmag * 64'd2977044472 + 64'h8000_0000) >> 32;
    l2   = (lmag * lmag + 64'h80_0000) >> 24;
    l3   = (l2 * lmag + 64'h80_0000) >> 24;
    acc  = signed_term(ca, 64'd1, 24, 1'b0) + signed_term(cb, lmag, 0, lneg)
         + signed_term(cd, l3, 0, lneg);
    pneg = acc[127];
    if (pneg) acc = -acc;
    if (acc[127:64] >= 64'(1) << 22) begin
      t = -27315;
    end else begin
      m50 = 64'(acc >> 24);
      if (m50 == 0) begin
        t = pneg ? -32768 : 32767;
      end else begin
        q = ((64'd100 << 50) + m50 / 2) / m50;
        t = (pneg ? -longint'(q) : longint'(q)) - 27315;
      end
    end
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return {1'b1, 16'(t)};
  endfunction

  function void note_sample(logic [15:0] s);
    temps_due.push_back(convert(s));
  endfunction

  function void check_temp(logic [15:0] temp, logic ok);
    logic [16:0] want;
    checked++;
    if (temps_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected output word temp=%0d valid=%0b", $signed(temp), ok);
      return;
    end
    want = temps_due.pop_front();
    if (want != {ok, temp}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected temp=%0d valid=%0b, got temp=%0d valid=%0b",
                 $signed(want[15:0]), want[16], $signed(temp), ok);
    end
  endfunction
endclass

module tb_ntc_adc_to_temperature_unit;
  import ntc_pkg::*;

  logic                clk, rst_n;
  logic                in_tvalid, in_tready;
  logic [15:0]         in_tdata;
  logic                out_tvalid, out_tready;
  logic [15:0]         out_tdata;
  logic                out_tuser;
  logic                cfg_we;
  logic [2:0]          cfg_addr;
  logic [CFG_W-1:0]    cfg_wdata;

  temp_scoreboard sb = new();
  int  send_idle_pct, recv_stall_pct;
  int  cycles, words_sent;
  bit  rx_en;

  ntc_adc_to_temperature_unit dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
    if (rx_en && out_tvalid && out_tready) sb.check_temp(out_tdata, out_tuser);
  end

  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic send_sample(logic [15:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = s;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(s);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.temps_due.size() != 0) @(negedge clk);
    // pipe is 51 deep, give it room before touching registers
    repeat (70) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_FULL_SCALE: sb.full_scale = v[15:0];
      REG_R1:         sb.r1_ohms = v[19:0];
      REG_COEF_A:     sb.ca = v[55:0];
      REG_COEF_B:     sb.cb = v[55:0];
      default:        sb.cd = v[55:0];
    endcase
  endtask

  task automatic set_mode(int m);
    send_idle_pct  = (m == 1) ? 67 : (m == 3) ? 10 : 0;
    recv_stall_pct = (m == 2) ? 67 : (m == 3) ? 10 : 0;
  endtask

  task automatic random_run(int n);
    logic [15:0] s;
    for (int i = 0; i < n; i++) begin
      if (sb.full_scale > 1 && $urandom_range(99) < 85)
        s = 16'($urandom_range(sb.full_scale - 1, 1));
      else
        s = 16'($urandom);
      send_sample(s);
    end
  endtask

  function automatic logic [55:0] near_default(logic signed [55:0] c);
    return c + 56'($signed($urandom_range(2000)) - 1000) * (c >>> 10);
  endfunction

  initial begin
    logic [15:0] edge_codes[$];
    rst_n = 0; in_tvalid = 0; in_tdata = 0; out_tready = 0;
    cfg_we = 0; cfg_addr = REG_FULL_SCALE; cfg_wdata = '0;
    cycles = 0; words_sent = 0; rx_en = 0;
    set_mode(0);
    repeat (10) @(negedge clk);
    rst_n = 1;
    rx_en = 1;

    // reset defaults: edges of the valid range and out of range codes
    edge_codes = '{16'd0, 16'd1, 16'd2, 16'd2048, 16'd4094, 16'd4095, 16'd4096, 16'hFFFF};
    foreach (edge_codes[i]) send_sample(edge_codes[i]);
    drain();

    write_reg(REG_FULL_SCALE, 65535);
    write_reg(REG_R1, 20'hFFFFF);
    edge_codes = '{16'h5555, 16'hAAAA, 16'd65534, 16'h8000, 16'h7FFF, 16'd1};
    foreach (edge_codes[i]) send_sample(edge_codes[i]);
    drain();

    // zero divider resistor, then full scale of one: everything invalid
    write_reg(REG_R1, 0);
    send_sample(16'd100); send_sample(16'd0);
    drain();
    write_reg(REG_R1, 1);
    write_reg(REG_FULL_SCALE, 1);
    send_sample(16'd0); send_sample(16'd1);
    drain();

    // vanishing polynomial saturates, negative polynomial goes cold
    write_reg(REG_FULL_SCALE, 4095);
    write_reg(REG_COEF_A, 0);
    write_reg(REG_COEF_B, 0);
    write_reg(REG_COEF_D, 0);
    send_sample(16'd1000);
    drain();
    write_reg(REG_COEF_A, 56'h80_0000_0000_0000);
    send_sample(16'd1000);
    drain();
    write_reg(REG_COEF_A, 56'h7F_FFFF_FFFF_FFFF);
    write_reg(REG_COEF_B, 56'h80_0000_0000_0000);
    write_reg(REG_COEF_D, 56'h7F_FFFF_FFFF_FFFF);
    send_sample(16'd10); send_sample(16'd4000);
    drain();

    for (int p = 0; p < 12; p++) begin
      set_mode(p % 4);
      if (p < 4) begin
        write_reg(REG_FULL_SCALE, p[0] ? 65535 : 4095);
        write_reg(REG_R1, p[1] ? 20'hFFFFF : 20'd10000);
        write_reg(REG_COEF_A, 56'sd11931378499532);
        write_reg(REG_COEF_B, -56'sd2663411417683);
        write_reg(REG_COEF_D, 56'sd29953198331);
      end else begin
        write_reg(REG_FULL_SCALE, $urandom_range(65535, 2));
        write_reg(REG_R1, $urandom_range(20'hFFFFF, 1));
        if (p % 3 == 0) begin
          write_reg(REG_COEF_A, {$urandom, $urandom});
          write_reg(REG_COEF_B, {$urandom, $urandom});
          write_reg(REG_COEF_D, {$urandom, $urandom});
        end else begin
          write_reg(REG_COEF_A, near_default(56'sd11931378499532));
          write_reg(REG_COEF_B, near_default(-56'sd2663411417683));
          write_reg(REG_COEF_D, near_default(56'sd29953198331));
        end
      end
      random_run(136);
      drain();
    end

    $display("covered %0d samples over 19 register settings, %0d output words checked",
             words_sent, sb.checked);
    $display("idle modes: none, sender gaps, receiver stalls, both; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.temps_due.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
